// ===== sv/text_console_cell_writer_unit_defines.svh =====
// Assertion macros for the text console cell writer.
// Used by the modules that carry concurrent checks; needs clk and arst_n in scope.
`ifndef TEXT_CONSOLE_CELL_WRITER_UNIT_DEFINES_SVH
`define TEXT_CONSOLE_CELL_WRITER_UNIT_DEFINES_SVH

// same-cycle implication, off while reset is asserted
`define TCCW_ASSERT_HOLDS(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, off while reset is asserted
`define TCCW_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/tccw_pkg.sv =====
// Shared types, constants and helpers for the text console cell writer.
// No dependencies; imported by the top, front and back modules of the block.
package tccw_pkg;

	// screen geometry
	localparam int ROWS    = 25;
	localparam int COLUMNS = 80;
	localparam int CELLS   = ROWS * COLUMNS;
	localparam int RW      = $clog2(ROWS);
	localparam int CW      = $clog2(COLUMNS + 1);
	localparam int AW      = $clog2(CELLS);

	// field widths
	localparam int CODE_W  = 8;
	localparam int PEN_W   = 4;
	localparam int CELL_W  = CODE_W + 2 * PEN_W;
	localparam int RROW_W  = 5;
	localparam int RCOL_W  = 7;
	localparam int CROW_W  = 5;
	localparam int CCOL_W  = 7;
	localparam int TYPE_W  = 2;
	localparam int CFG_IDX_W = 1;

	// queues
	localparam int CQ_DEPTH = 4;
	localparam int CQ_PW    = $clog2(CQ_DEPTH);
	localparam int CQ_CW    = $clog2(CQ_DEPTH + 1);
	localparam int OQ_DEPTH = 2;
	localparam int OQ_PW    = $clog2(OQ_DEPTH);
	localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

	// character codes
	localparam logic [CODE_W-1:0] CODE_LF    = 8'd10;
	localparam logic [CODE_W-1:0] CODE_CR    = 8'd13;
	localparam logic [CODE_W-1:0] CODE_BS    = 8'd8;
	localparam logic [CODE_W-1:0] CODE_TAB   = 8'd9;
	localparam logic [CODE_W-1:0] CODE_SPACE = 8'd32;
	localparam int TAB_STOP = 8;

	// request types
	localparam logic [TYPE_W-1:0] REQ_PUT   = 2'd0;
	localparam logic [TYPE_W-1:0] REQ_READ  = 2'd1;
	localparam logic [TYPE_W-1:0] REQ_CLEAR = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PEN_FG = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_PEN_BG = 1'b1;

	// reset colors
	localparam logic [PEN_W-1:0] RESET_FG = 4'd7;
	localparam logic [PEN_W-1:0] RESET_BG = 4'd0;

	typedef struct packed {
		logic [TYPE_W-1:0] req_type;
		logic [CODE_W-1:0] char_byte;
		logic [RROW_W-1:0] read_row;
		logic [RCOL_W-1:0] read_column;
	} req_t;

	typedef struct packed {
		logic [CODE_W-1:0] cell_code;
		logic [PEN_W-1:0]  cell_fg;
		logic [PEN_W-1:0]  cell_bg;
		logic [CROW_W-1:0] cursor_row_out;
		logic [CCOL_W-1:0] cursor_col_out;
		logic              scrolled;
	} res_t;

	typedef struct packed {
		logic [PEN_W-1:0] fg;
		logic [PEN_W-1:0] bg;
	} pen_t;

	typedef enum logic [2:0] {
		OP_NOP,
		OP_PUT,
		OP_LF,
		OP_CR,
		OP_BS,
		OP_TAB,
		OP_READ,
		OP_CLEAR
	} op_t;

	// classified command handed from front to back
	typedef struct packed {
		op_t               op;
		logic [CODE_W-1:0] code;
		logic [RROW_W-1:0] rrow;
		logic [RCOL_W-1:0] rcol;
		logic              read_ok;
	} cmd_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_EXEC,
		ST_BLANK,
		ST_CLEAR,
		ST_ADDR,
		ST_ACCESS,
		ST_DONE
	} state_t;

	// cell layout: bg in the top nibble, fg next, code in the low byte
	function automatic logic [CELL_W-1:0] make_cell(logic [CODE_W-1:0] code,
			logic [PEN_W-1:0] fg, logic [PEN_W-1:0] bg);
		return {bg, fg, code};
	endfunction

endpackage

// ===== sv/text_console_cell_writer_unit.sv =====
// Text console cell writer: request queue, command sequencer, cell RAM, result queue.
// Each command passes the sequencer states IDLE and EXEC; a put, or a backspace past column zero,
// then goes through ADDR and ACCESS, an in-range read through ADDR, ACCESS and DONE, and the rest
// through DONE; a scroll first blanks the recycled row in BLANK, a clear blanks the store in CLEAR.
// The single-port cell RAM sequencer takes a new command only in IDLE, with room in the result queue.
// Reset: async low; then a blanking pass over every cell in reset colors with full held high.
module text_console_cell_writer_unit import tccw_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  req_t                 request,
	output logic                 empty,
	input  logic                 pop,
	output res_t                 result,
	input  logic                 wr_en,
	input  logic [CFG_IDX_W-1:0] wr_index,
	input  logic [PEN_W-1:0]     wr_data
);

	pen_t pen_q;
	logic cmd_valid;
	cmd_t cmd;
	logic cmd_pop;
	logic init_busy;

	// pen color registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pen_q.fg <= RESET_FG;
			pen_q.bg <= RESET_BG;
		end else if (wr_en) begin
			case (wr_index)
				REG_PEN_FG: pen_q.fg <= wr_data;
				REG_PEN_BG: pen_q.bg <= wr_data;
				default:    pen_q    <= pen_q;
			endcase
		end
	end

	tccw_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.request  (request),
		.hold     (init_busy),
		.cmd_valid(cmd_valid),
		.cmd      (cmd),
		.cmd_pop  (cmd_pop)
	);

	tccw_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd      (cmd),
		.cmd_pop  (cmd_pop),
		.pen      (pen_q),
		.init_busy(init_busy),
		.pop      (pop),
		.empty    (empty),
		.result   (result)
	);

endmodule

// ===== sv/tccw_ram.sv =====
// Generic single-port RAM with registered read data.
// No dependencies.
module tccw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write, and read-before-write on the same port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

// ===== sv/tccw_front.sv =====
// Front end: accepts requests, classifies them and queues the commands.
// Depends on tccw_pkg.
module tccw_front import tccw_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  req_t request,
	input  logic hold,
	output logic cmd_valid,
	output cmd_t cmd,
	input  logic cmd_pop
);

	cmd_t             cq_mem_q [CQ_DEPTH];
	logic [CQ_PW-1:0] cq_wr_q;
	logic [CQ_PW-1:0] cq_rd_q;
	logic [CQ_CW-1:0] cq_cnt_q;
	cmd_t             cls;
	logic             accept;

	// decode request into a command
	always_comb begin
		cls.code    = request.char_byte;
		cls.rrow    = request.read_row;
		cls.rcol    = request.read_column;
		cls.read_ok = (32'(request.read_row) < ROWS) && (32'(request.read_column) < COLUMNS);
		case (request.req_type)
			REQ_PUT: begin
				case (request.char_byte)
					CODE_LF:  cls.op = OP_LF;
					CODE_CR:  cls.op = OP_CR;
					CODE_BS:  cls.op = OP_BS;
					CODE_TAB: cls.op = OP_TAB;
					default:  cls.op = OP_PUT;
				endcase
			end
			REQ_READ:  cls.op = OP_READ;
			REQ_CLEAR: cls.op = OP_CLEAR;
			default:   cls.op = OP_NOP;
		endcase
	end

	assign full      = (cq_cnt_q == CQ_CW'(CQ_DEPTH)) || hold;
	assign accept    = push && !full;
	assign cmd_valid = (cq_cnt_q != '0);
	assign cmd       = cq_mem_q[cq_rd_q];

	// command queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cq_wr_q  <= '0;
			cq_rd_q  <= '0;
			cq_cnt_q <= '0;
		end else begin
			if (accept) begin
				cq_wr_q <= (cq_wr_q == CQ_PW'(CQ_DEPTH - 1)) ? '0 : cq_wr_q + CQ_PW'(1);
			end
			if (cmd_pop) begin
				cq_rd_q <= (cq_rd_q == CQ_PW'(CQ_DEPTH - 1)) ? '0 : cq_rd_q + CQ_PW'(1);
			end
			case ({accept, cmd_pop})
				2'b10:   cq_cnt_q <= cq_cnt_q + CQ_CW'(1);
				2'b01:   cq_cnt_q <= cq_cnt_q - CQ_CW'(1);
				default: cq_cnt_q <= cq_cnt_q;
			endcase
		end
	end

	// command queue storage
	always_ff @(posedge clk) begin
		if (accept) begin
			cq_mem_q[cq_wr_q] <= cls;
		end
	end

endmodule

// ===== sv/tccw_back.sv =====
// Back end: sequencer owning the cursor, the cell RAM and the result queue.
// Depends on tccw_pkg, tccw_ram and the assertion macro header.
`include "text_console_cell_writer_unit_defines.svh"

module tccw_back import tccw_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	input  cmd_t cmd,
	output logic cmd_pop,
	input  pen_t pen,
	output logic init_busy,
	input  logic pop,
	output logic empty,
	output res_t result
);

	localparam logic [AW-1:0] LAST_ADDR = AW'(CELLS - 1);

	state_t            state_q, state_d;
	cmd_t              cmd_q, cmd_d;
	logic [RW-1:0]     cur_row_q, cur_row_d;
	logic [CW-1:0]     cur_col_q, cur_col_d;
	logic [AW-1:0]     top_base_q, top_base_d;
	logic [AW-1:0]     addr_q, addr_d;
	logic [CW-1:0]     cnt_q, cnt_d;
	logic [RW-1:0]     tgt_row_q, tgt_row_d;
	logic [CW-1:0]     tgt_col_q, tgt_col_d;
	logic [CELL_W-1:0] wdata_q, wdata_d;
	logic              rd_q, rd_d;
	logic              scr_q, scr_d;
	logic              after_q, after_d;

	logic              ram_we;
	logic [AW-1:0]     ram_addr;
	logic [CELL_W-1:0] ram_wdata;
	logic [CELL_W-1:0] ram_rdata;

	logic              lf_last;
	logic [RW-1:0]     lf_row_n;
	logic              wrap;
	logic [CW:0]       stop_sum;
	logic [AW:0]       base_sum;
	logic [AW-1:0]     next_base;
	logic [AW:0]       row_off;
	logic [AW:0]       addr_sum;
	logic [AW:0]       phys_off;
	logic [CELL_W-1:0] blank_cell;
	logic              do_lf;

	res_t              oq_mem_q [OQ_DEPTH];
	logic [OQ_PW-1:0]  oq_wr_q;
	logic [OQ_PW-1:0]  oq_rd_q;
	logic [OQ_CW-1:0]  oq_cnt_q;
	logic              oq_push;
	logic              oq_pop;
	logic [CELL_W-1:0] res_cell;
	res_t              res_new;

	tccw_ram #(
		.WIDTH(CELL_W),
		.DEPTH(CELLS)
	) u_cells (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	// cursor helpers
	assign lf_last    = (cur_row_q == RW'(ROWS - 1));
	assign lf_row_n   = lf_last ? cur_row_q : cur_row_q + RW'(1);
	assign wrap       = (cur_col_q >= CW'(COLUMNS));
	assign stop_sum   = ({1'b0, cur_col_q} & ~(CW+1)'(TAB_STOP - 1)) + (CW+1)'(TAB_STOP);
	assign blank_cell = make_cell(CODE_SPACE, pen.fg, pen.bg);

	// top-row base moves one row on a scroll, wrapping at the end of the store
	assign base_sum  = {1'b0, top_base_q} + (AW+1)'(COLUMNS);
	assign next_base = (base_sum >= (AW+1)'(CELLS)) ? '0 : AW'(base_sum);

	// logical row to physical address
	assign row_off  = (AW+1)'(tgt_row_q) * (AW+1)'(COLUMNS);
	assign addr_sum = row_off + {1'b0, top_base_q};
	assign phys_off = (addr_sum >= (AW+1)'(CELLS)) ? addr_sum - (AW+1)'(CELLS) : addr_sum;

	assign init_busy = (state_q == ST_INIT);

	// sequencer: next state and datapath controls
	always_comb begin
		state_d    = state_q;
		cmd_d      = cmd_q;
		cur_row_d  = cur_row_q;
		cur_col_d  = cur_col_q;
		top_base_d = top_base_q;
		addr_d     = addr_q;
		cnt_d      = cnt_q;
		tgt_row_d  = tgt_row_q;
		tgt_col_d  = tgt_col_q;
		wdata_d    = wdata_q;
		rd_d       = rd_q;
		scr_d      = scr_q;
		after_d    = after_q;
		cmd_pop    = 1'b0;
		ram_we     = 1'b0;
		ram_addr   = addr_q;
		ram_wdata  = wdata_q;
		oq_push    = 1'b0;
		res_cell   = '0;
		do_lf      = 1'b0;
		case (state_q)
			// clearing pass after reset, fixed reset colors
			ST_INIT: begin
				ram_we    = 1'b1;
				ram_wdata = make_cell(CODE_SPACE, RESET_FG, RESET_BG);
				addr_d    = addr_q + AW'(1);
				if (addr_q == LAST_ADDR) begin
					addr_d  = '0;
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (cmd_valid && (oq_cnt_q != OQ_CW'(OQ_DEPTH))) begin
					cmd_pop = 1'b1;
					cmd_d   = cmd;
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				scr_d   = 1'b0;
				rd_d    = 1'b0;
				after_d = 1'b0;
				state_d = ST_DONE;
				case (cmd_q.op)
					OP_PUT: begin
						wdata_d = make_cell(cmd_q.code, pen.fg, pen.bg);
						after_d = 1'b1;
						state_d = ST_ADDR;
						if (wrap) begin
							do_lf     = 1'b1;
							tgt_row_d = lf_row_n;
							tgt_col_d = '0;
							cur_col_d = CW'(1);
						end else begin
							tgt_row_d = cur_row_q;
							tgt_col_d = cur_col_q;
							cur_col_d = cur_col_q + CW'(1);
						end
					end
					OP_LF: begin
						do_lf     = 1'b1;
						cur_col_d = '0;
					end
					OP_CR: begin
						cur_col_d = '0;
					end
					OP_BS: begin
						if (cur_col_q != '0) begin
							cur_col_d = cur_col_q - CW'(1);
							tgt_row_d = cur_row_q;
							tgt_col_d = cur_col_q - CW'(1);
							wdata_d   = blank_cell;
							state_d   = ST_ADDR;
						end
					end
					OP_TAB: begin
						if (stop_sum >= (CW+1)'(COLUMNS)) begin
							do_lf     = 1'b1;
							cur_col_d = '0;
						end else begin
							cur_col_d = CW'(stop_sum);
						end
					end
					OP_READ: begin
						if (cmd_q.read_ok) begin
							tgt_row_d = RW'(cmd_q.rrow);
							tgt_col_d = CW'(cmd_q.rcol);
							rd_d      = 1'b1;
							state_d   = ST_ADDR;
						end
					end
					OP_CLEAR: begin
						cur_row_d  = '0;
						cur_col_d  = '0;
						top_base_d = '0;
						addr_d     = '0;
						state_d    = ST_CLEAR;
					end
					default: begin
					end
				endcase
				// line feed, scrolling on the last row
				if (do_lf) begin
					cur_row_d = lf_row_n;
					if (lf_last) begin
						scr_d      = 1'b1;
						addr_d     = top_base_q;
						top_base_d = next_base;
						cnt_d      = '0;
						state_d    = ST_BLANK;
					end
				end
			end
			// blank the recycled row in pen colors
			ST_BLANK: begin
				ram_we    = 1'b1;
				ram_wdata = blank_cell;
				addr_d    = addr_q + AW'(1);
				cnt_d     = cnt_q + CW'(1);
				if (cnt_q == CW'(COLUMNS - 1)) begin
					state_d = after_q ? ST_ADDR : ST_DONE;
				end
			end
			// blank the whole store in pen colors
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_wdata = blank_cell;
				addr_d    = addr_q + AW'(1);
				if (addr_q == LAST_ADDR) begin
					state_d = ST_DONE;
				end
			end
			ST_ADDR: begin
				addr_d  = AW'(phys_off) + AW'(tgt_col_q);
				state_d = ST_ACCESS;
			end
			ST_ACCESS: begin
				if (rd_q) begin
					state_d = ST_DONE;
				end else begin
					ram_we  = 1'b1;
					oq_push = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_DONE: begin
				oq_push  = 1'b1;
				res_cell = rd_q ? ram_rdata : '0;
				state_d  = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_INIT;
			cur_row_q  <= '0;
			cur_col_q  <= '0;
			top_base_q <= '0;
			addr_q     <= '0;
			cnt_q      <= '0;
			rd_q       <= 1'b0;
			scr_q      <= 1'b0;
			after_q    <= 1'b0;
		end else begin
			state_q    <= state_d;
			cur_row_q  <= cur_row_d;
			cur_col_q  <= cur_col_d;
			top_base_q <= top_base_d;
			addr_q     <= addr_d;
			cnt_q      <= cnt_d;
			rd_q       <= rd_d;
			scr_q      <= scr_d;
			after_q    <= after_d;
		end
	end

	// command payload and cell target
	always_ff @(posedge clk) begin
		cmd_q     <= cmd_d;
		tgt_row_q <= tgt_row_d;
		tgt_col_q <= tgt_col_d;
		wdata_q   <= wdata_d;
	end

	// result item
	always_comb begin
		res_new.cell_code      = res_cell[CODE_W-1:0];
		res_new.cell_fg        = res_cell[CODE_W +: PEN_W];
		res_new.cell_bg        = res_cell[CODE_W + PEN_W +: PEN_W];
		res_new.cursor_row_out = CROW_W'(cur_row_q);
		res_new.cursor_col_out = CCOL_W'(cur_col_q);
		res_new.scrolled       = scr_q;
	end

	// result queue
	assign empty  = (oq_cnt_q == '0);
	assign oq_pop = pop && !empty;
	assign result = oq_mem_q[oq_rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_wr_q  <= '0;
			oq_rd_q  <= '0;
			oq_cnt_q <= '0;
		end else begin
			if (oq_push) begin
				oq_wr_q <= (oq_wr_q == OQ_PW'(OQ_DEPTH - 1)) ? '0 : oq_wr_q + OQ_PW'(1);
			end
			if (oq_pop) begin
				oq_rd_q <= (oq_rd_q == OQ_PW'(OQ_DEPTH - 1)) ? '0 : oq_rd_q + OQ_PW'(1);
			end
			case ({oq_push, oq_pop})
				2'b10:   oq_cnt_q <= oq_cnt_q + OQ_CW'(1);
				2'b01:   oq_cnt_q <= oq_cnt_q - OQ_CW'(1);
				default: oq_cnt_q <= oq_cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (oq_push) begin
			oq_mem_q[oq_wr_q] <= res_new;
		end
	end

	// checks
	`TCCW_ASSERT_HOLDS(a_oq_no_overflow, oq_push && !oq_pop, oq_cnt_q != OQ_CW'(OQ_DEPTH), "result queue overflow")
	`TCCW_ASSERT_NEXT(a_pop_to_exec, cmd_pop, state_q == ST_EXEC, "popped command not executed")
	`TCCW_ASSERT_HOLDS(a_access_in_range, state_q == ST_ACCESS, 32'(addr_q) < CELLS, "cell address out of range")
	`TCCW_ASSERT_HOLDS(a_cursor_in_range, state_q != ST_INIT, (32'(cur_row_q) < ROWS) && (32'(cur_col_q) <= COLUMNS) && (32'(top_base_q) < CELLS), "cursor or top row out of range")

endmodule

// ===== verif/console_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the text console cell writer: keeps its own screen, cursor and pens,
// predicts the result of every accepted request and compares it with what comes back.
// Depends on tccw_pkg for the request and result types, the codes and the screen size.
module console_checker import tccw_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  logic                 full,
	input  req_t                 request,
	input  logic                 empty,
	input  logic                 pop,
	input  res_t                 result,
	input  logic                 wr_en,
	input  logic [CFG_IDX_W-1:0] wr_index,
	input  logic [PEN_W-1:0]     wr_data,
	output int                   fail_count,
	output int                   waiting,
	output int                   checked,
	output int                   scrolls
);

	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		logic [PEN_W-1:0]  bg;
		logic [PEN_W-1:0]  fg;
		logic [CODE_W-1:0] code;
	} glyph_t;

	glyph_t           screen [ROWS][COLUMNS];
	int               cur_row;
	int               cur_col;
	logic [PEN_W-1:0] pen_fg;
	logic [PEN_W-1:0] pen_bg;
	res_t             expected_results [$];
	res_t             want;
	logic             bad;
	int               errors;
	int               n_checked;
	int               n_scrolls;

	function automatic glyph_t blank_glyph();
		return {pen_bg, pen_fg, CODE_SPACE};
	endfunction

	function automatic void fill_screen(glyph_t g);
		for (int r = 0; r < ROWS; r++)
			for (int c = 0; c < COLUMNS; c++)
				screen[r][c] = g;
	endfunction

	// line feed; returns 1 when the screen rolled up
	function automatic logic next_line();
		logic rolled;
		rolled = 1'b0;
		cur_col = 0;
		if (cur_row + 1 < ROWS) begin
			cur_row++;
		end else begin
			for (int r = 0; r < ROWS - 1; r++)
				for (int c = 0; c < COLUMNS; c++)
					screen[r][c] = screen[r + 1][c];
			for (int c = 0; c < COLUMNS; c++)
				screen[ROWS - 1][c] = blank_glyph();
			rolled = 1'b1;
		end
		return rolled;
	endfunction

	// update the screen model for one request and build its result
	function automatic res_t apply_request(req_t rq);
		res_t   r;
		glyph_t g;
		int     stop_col;
		r = '0;
		case (rq.req_type)
			REQ_PUT: begin
				case (rq.char_byte)
					CODE_LF: r.scrolled = next_line();
					CODE_CR: cur_col = 0;
					CODE_BS: begin
						// nothing at column zero; with wrap pending it blanks the last column
						if (cur_col > 0) begin
							cur_col--;
							screen[cur_row][cur_col] = blank_glyph();
						end
					end
					CODE_TAB: begin
						stop_col = (cur_col / TAB_STOP + 1) * TAB_STOP;
						if (stop_col + 1 > COLUMNS)
							r.scrolled = next_line();
						else
							cur_col = stop_col;
					end
					default: begin
						if (cur_col >= COLUMNS)
							r.scrolled = next_line();
						screen[cur_row][cur_col] = {pen_bg, pen_fg, rq.char_byte};
						cur_col++;
					end
				endcase
			end
			REQ_READ: begin
				// out-of-range addresses read back as all zero
				if (rq.read_row < ROWS && rq.read_column < COLUMNS) begin
					g = screen[rq.read_row][rq.read_column];
					r.cell_code = g.code;
					r.cell_fg   = g.fg;
					r.cell_bg   = g.bg;
				end
			end
			REQ_CLEAR: begin
				fill_screen(blank_glyph());
				cur_row = 0;
				cur_col = 0;
			end
			default: ; // unused type: cursor only
		endcase
		r.cursor_row_out = CROW_W'(cur_row);
		r.cursor_col_out = CCOL_W'(cur_col);
		return r;
	endfunction

	// predict on accepted requests, compare on accepted results
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_screen({RESET_BG, RESET_FG, CODE_SPACE});
			cur_row = 0;
			cur_col = 0;
			pen_fg = RESET_FG;
			pen_bg = RESET_BG;
			expected_results.delete();
			errors = 0;
			n_checked = 0;
			n_scrolls = 0;
			fail_count <= 0;
			waiting <= 0;
			checked <= 0;
			scrolls <= 0;
		end else begin
			if (wr_en) begin
				case (wr_index)
					REG_PEN_FG: pen_fg = wr_data;
					REG_PEN_BG: pen_bg = wr_data;
					default: ;
				endcase
			end
			if (push && !full) begin
				want = apply_request(request);
				if (want.scrolled)
					n_scrolls++;
				expected_results.push_back(want);
			end
			if (pop && !empty) begin
				if (expected_results.size() == 0) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("unexpected result with nothing pending: %h", result);
				end else begin
					want = expected_results.pop_front();
					bad = (result.cell_code !== want.cell_code)
						|| (result.cell_fg !== want.cell_fg)
						|| (result.cell_bg !== want.cell_bg)
						|| (result.cursor_row_out !== want.cursor_row_out)
						|| (result.cursor_col_out !== want.cursor_col_out)
						|| (result.scrolled !== want.scrolled);
					if (bad) begin
						errors++;
						if (errors <= MAX_REPORTS) begin
							$display("mismatch on result %0d (expected/actual): code %h/%h fg %h/%h bg %h/%h",
								n_checked, want.cell_code, result.cell_code,
								want.cell_fg, result.cell_fg, want.cell_bg, result.cell_bg);
							$display("  row %0d/%0d col %0d/%0d scrolled %b/%b",
								want.cursor_row_out, result.cursor_row_out,
								want.cursor_col_out, result.cursor_col_out,
								want.scrolled, result.scrolled);
						end
					end
				end
				n_checked++;
			end
			fail_count <= errors;
			waiting <= expected_results.size();
			checked <= n_checked;
			scrolls <= n_scrolls;
		end
	end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// Top of the text console cell writer testbench: clock, reset, request and pen stimulus,
// result draining and the verdict. Needs tccw_pkg, the block and console_checker.
module testbench;
	import tccw_pkg::*;

	localparam logic [TYPE_W-1:0] REQ_UNUSED = 2'd3;
	localparam int N_PHASES     = 6;
	localparam int PHASE_ITEMS  = 305;
	localparam int HOLD_CYCLES  = 400;
	localparam int STALL_LIMIT  = 12000;
	localparam int END_CYCLES   = 20;
	localparam int DRAIN_PAUSE  = 8;

	logic                 clk;
	logic                 arst_n;
	logic                 push;
	logic                 full;
	req_t                 request;
	logic                 empty;
	logic                 pop;
	res_t                 result;
	logic                 wr_en;
	logic [CFG_IDX_W-1:0] wr_index;
	logic [PEN_W-1:0]     wr_data;

	int fail_count;
	int waiting;
	int checked;
	int scrolls;

	// stimulus state shared by the sender and receiver
	bit allow_idle = 1'b1;
	bit quiet      = 1'b0;
	bit hold_req   = 1'b0;
	bit hold_done  = 1'b0;
	int n_sent     = 0;
	int n_reads    = 0;
	int n_clears   = 0;
	int n_pen_sets = 0;

	text_console_cell_writer_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.request  (request),
		.empty    (empty),
		.pop      (pop),
		.result   (result),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	console_checker u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.request    (request),
		.empty      (empty),
		.pop        (pop),
		.result     (result),
		.wr_en      (wr_en),
		.wr_index   (wr_index),
		.wr_data    (wr_data),
		.fail_count (fail_count),
		.waiting    (waiting),
		.checked    (checked),
		.scrolls    (scrolls)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// request with random don't-care fields
	function automatic req_t mk_op(logic [TYPE_W-1:0] kind);
		req_t q;
		q.req_type    = kind;
		q.char_byte   = CODE_W'($urandom_range(0, 255));
		q.read_row    = RROW_W'($urandom_range(0, 31));
		q.read_column = RCOL_W'($urandom_range(0, 127));
		return q;
	endfunction

	function automatic req_t mk_put(logic [CODE_W-1:0] b);
		req_t q;
		q = mk_op(REQ_PUT);
		q.char_byte = b;
		return q;
	endfunction

	function automatic req_t mk_read(int row, int col);
		req_t q;
		q = mk_op(REQ_READ);
		q.read_row    = RROW_W'(row);
		q.read_column = RCOL_W'(col);
		return q;
	endfunction

	// mostly text and line control, a fair share of reads, rare clears
	function automatic req_t random_req();
		int   pick;
		req_t q;
		pick = $urandom_range(0, 999);
		q = mk_op(REQ_UNUSED);
		if (pick < 450) begin
			q.req_type = REQ_PUT;
		end else if (pick < 570) begin
			q = mk_put(CODE_LF);
		end else if (pick < 610) begin
			q = mk_put(CODE_CR);
		end else if (pick < 660) begin
			q = mk_put(CODE_BS);
		end else if (pick < 720) begin
			q = mk_put(CODE_TAB);
		end else if (pick < 940) begin
			q.req_type = REQ_READ;
			if ($urandom_range(0, 9) < 8) begin
				q.read_row    = RROW_W'($urandom_range(0, ROWS - 1));
				q.read_column = RCOL_W'($urandom_range(0, COLUMNS - 1));
			end
		end else if (pick >= 996) begin
			q.req_type = REQ_CLEAR;
		end
		return q;
	endfunction

	// offer one request, with an occasional gap first, and wait for it to be taken
	task automatic send_req(input req_t rq);
		if (n_sent % 64 == 0)
			quiet = ($urandom_range(0, 2) == 0);
		if (allow_idle && !quiet && $urandom_range(0, 4) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		push <= 1'b1;
		request <= rq;
		@(posedge clk);
		while (full) @(posedge clk);
		n_sent++;
		if (rq.req_type == REQ_READ)
			n_reads++;
		if (rq.req_type == REQ_CLEAR)
			n_clears++;
	endtask

	// stop offering and wait until every result is back
	task automatic drain();
		push <= 1'b0;
		@(posedge clk);
		while (waiting != 0) @(posedge clk);
		repeat (DRAIN_PAUSE) @(posedge clk);
	endtask

	task automatic set_pens(input logic [PEN_W-1:0] fg, input logic [PEN_W-1:0] bg);
		wr_en <= 1'b1;
		wr_index <= REG_PEN_FG;
		wr_data <= fg;
		@(posedge clk);
		wr_index <= REG_PEN_BG;
		wr_data <= bg;
		@(posedge clk);
		wr_en <= 1'b0;
		@(posedge clk);
		n_pen_sets++;
	endtask

	// random traffic with bursts of full text lines to reach wrap and scroll
	task automatic run_text(input int n);
		int               done;
		int               len;
		logic [CODE_W-1:0] b;
		done = 0;
		while (done < n) begin
			if ($urandom_range(0, 99) < 4) begin
				len = $urandom_range(60, 90);
				for (int k = 0; k < len; k++) begin
					do
						b = CODE_W'($urandom_range(0, 255));
					while (b == CODE_LF || b == CODE_CR || b == CODE_BS || b == CODE_TAB);
					send_req(mk_put(b));
				end
				done += len;
			end else begin
				send_req(random_req());
				done++;
			end
		end
	endtask

	// result side: random stalls, one long hold-off
	initial begin
		pop <= 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (hold_req && !hold_done) begin
				pop <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
			end else if (allow_idle && !quiet && $urandom_range(0, 5) == 0) begin
				pop <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
			end else begin
				pop <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// watchdog on cycles with no request or result taken
	initial begin
		int stalled;
		stalled = 0;
		@(posedge arst_n);
		while (stalled < STALL_LIMIT) begin
			@(posedge clk);
			if ((push && !full) || (pop && !empty))
				stalled = 0;
			else
				stalled++;
		end
		$display("simulation failed");
		$finish;
	end

	// main sequence
	initial begin
		logic [PEN_W-1:0] fg_plan [N_PHASES];
		logic [PEN_W-1:0] bg_plan [N_PHASES];
		fg_plan = '{4'h0, 4'hF, 4'h0, 4'h0, 4'h0, 4'h7};
		bg_plan = '{4'hF, 4'hF, 4'h0, 4'h0, 4'h0, 4'h0};
		arst_n <= 1'b0;
		push <= 1'b0;
		request <= '0;
		wr_en <= 1'b0;
		wr_index <= REG_PEN_FG;
		wr_data <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		// block blanks its RAM after reset with full held high
		while (full) @(posedge clk);
		set_pens(4'hF, 4'h0);

		// directed: edge cases of the cursor logic
		send_req(mk_put(CODE_BS));        // backspace at column zero
		send_req(mk_put(8'h00));          // zero byte is printable
		send_req(mk_read(0, 0));
		repeat (9) send_req(mk_put(CODE_TAB)); // stops 8 .. 72
		send_req(mk_put(8'hFF));
		repeat (7) send_req(mk_put(8'h41));    // column reaches the width
		send_req(mk_put(CODE_BS));        // backspace with wrap pending
		send_req(mk_put(8'h7E));
		send_req(mk_put(8'h5A));          // printable wraps to next row
		send_req(mk_put(CODE_TAB));
		send_req(mk_put(CODE_CR));
		send_req(mk_put(CODE_LF));
		send_req(mk_read(0, 79));
		send_req(mk_read(25, 5));         // row out of range
		send_req(mk_read(3, 127));        // column out of range
		send_req(mk_op(REQ_UNUSED));
		send_req(mk_op(REQ_CLEAR));
		send_req(mk_read(24, 0));

		// random phases, one pen setting each; last one runs without idling
		for (int p = 0; p < N_PHASES; p++) begin
			drain();
			if (p == 3 || p == 4)
				set_pens(PEN_W'($urandom_range(0, 15)), PEN_W'($urandom_range(0, 15)));
			else
				set_pens(fg_plan[p], bg_plan[p]);
			allow_idle = (p != N_PHASES - 1);
			if (p == 0)
				hold_req = 1'b1;
			run_text(PHASE_ITEMS);
		end
		drain();
		repeat (END_CYCLES) @(posedge clk);

		$display("%0d requests (%0d reads, %0d clears), %0d results checked, %0d scrolls",
			n_sent, n_reads, n_clears, checked, scrolls);
		$display("%0d pen settings, one %0d-cycle output hold-off, drained between settings",
			n_pen_sets, HOLD_CYCLES);
		if (fail_count == 0 && waiting == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ===== text_console_cell_writer_unit.f =====
+incdir+sv
sv/tccw_pkg.sv
sv/tccw_ram.sv
sv/tccw_front.sv
sv/tccw_back.sv
sv/text_console_cell_writer_unit.sv
verif/console_checker.sv
verif/testbench.sv
